// ===== rtl/bhs_pkg.sv =====
// Shared types, widths and codes for the bilinear heightmap sampler.
package bhs_pkg;

  // Default grid limits for the top-level parameters
  localparam int MAX_GRID_W_DEF = 256;
  localparam int MAX_GRID_H_DEF = 256;

  // Field widths
  localparam int COORD_W  = 32;  // Q16.16 world coordinate
  localparam int SCALE_W  = 24;  // Q8.16 cells per world unit
  localparam int DIM_W    = 9;   // grid width / height register
  localparam int IDX_W    = 16;  // sample store index
  localparam int SAMPLE_W = 16;  // signed height sample
  localparam int FRAC_W   = 16;  // blend fraction
  localparam int HEIGHT_W = 24;  // result, 8 fraction bits
  localparam int PROD_W   = COORD_W + SCALE_W;

  // Stream payload widths
  localparam int IN_TDATA_W  = 2 * COORD_W + IDX_W + SAMPLE_W;
  localparam int OUT_TDATA_W = HEIGHT_W;

  // APB port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 4;

  typedef enum logic [1:0] {
    REG_GRID_W  = 2'd0,
    REG_GRID_H  = 2'd1,
    REG_SCALE_X = 2'd2,
    REG_SCALE_Z = 2'd3
  } bhs_reg_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } bhs_func_e;

  // Store port control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } bhs_store_ctl_t;

endpackage

// ===== rtl/bilinear_heightmap_sampler.sv =====
// Top level of the bilinear heightmap sampler: config, pipeline and output register.
//
// Usage:
//   s_axis carries one request per beat. tuser = func: a write request stores
//   sample_value at sample_index and gives no result; a query request carries
//   a world position (coord_x, coord_z) and gives one height on m_axis.
//   APB registers: grid_width at 0x0, grid_height at 0x4, scale_x at 0x8,
//   scale_z at 0xC. Write them only while no request is in flight.
//   Pipeline: a query passes six register stages (product, cell locate,
//   address, store read, horizontal blend, vertical blend/output). Writes
//   reach the store at the same stage as query reads, so requests keep
//   their order with no forwarding.
//   Throughput: one request per cycle unless m_axis stalls. The four neighbour
//   reads come from two store copies, each with two read ports, in the same cycle.
//   Stall: every stage holds its own valid bit and only stalls when the stage
//   after it is full and stalled, so bubbles are squeezed out and s_axis keeps
//   accepting while a finished height waits in the output register.
//   Reset: registers read zero (zero grid, queries return 0), pipeline empty.
//   The store is not cleared; query only cells that were written.
module bilinear_heightmap_sampler import bhs_pkg::*; #(
  parameter int MAX_GRID_W = MAX_GRID_W_DEF,
  parameter int MAX_GRID_H = MAX_GRID_H_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] coord_x, [63:32] coord_z, [79:64] sample_index, [95:80] sample_value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic                   s_axis_tuser,
  // stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [23:0] height
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // APB config
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int XW    = $clog2(MAX_GRID_W);
  localparam int ZW    = $clog2(MAX_GRID_H);
  localparam int WEW   = $clog2(MAX_GRID_W + 1);
  localparam int HEW   = $clog2(MAX_GRID_H + 1);
  localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = ZW + WEW;
  localparam int PK_W  = PROD_W - FRAC_W;  // product with low fraction dropped
  localparam int IP_W  = PK_W - FRAC_W;    // integer cell part
  localparam int NSTG  = 6;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]   grid_w_q, grid_h_q;
  logic [SCALE_W-1:0] scale_x_q, scale_z_q;
  bhs_reg_e           reg_sel;

  assign reg_sel = bhs_reg_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q  <= '0;
      grid_h_q  <= '0;
      scale_x_q <= '0;
      scale_z_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_GRID_W:  grid_w_q  <= pwdata[DIM_W-1:0];
        REG_GRID_H:  grid_h_q  <= pwdata[DIM_W-1:0];
        REG_SCALE_X: scale_x_q <= pwdata[SCALE_W-1:0];
        REG_SCALE_Z: scale_z_q <= pwdata[SCALE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_W:  prdata = APB_DATA_W'(grid_w_q);
      REG_GRID_H:  prdata = APB_DATA_W'(grid_h_q);
      REG_SCALE_X: prdata = APB_DATA_W'(scale_x_q);
      REG_SCALE_Z: prdata = APB_DATA_W'(scale_z_q);
      default:     prdata = '0;
    endcase
  end

  // Effective grid size, capped at the store geometry
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [XW-1:0]  last_x;
  logic [ZW-1:0]  last_z;

  always_comb begin
    w_eff  = (32'(grid_w_q) > 32'(MAX_GRID_W)) ? WEW'(MAX_GRID_W) : WEW'(grid_w_q);
    h_eff  = (32'(grid_h_q) > 32'(MAX_GRID_H)) ? HEW'(MAX_GRID_H) : HEW'(grid_h_q);
    last_x = XW'(w_eff - WEW'(1));
    last_z = ZW'(h_eff - HEW'(1));
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: stage k loads when it is empty or drains onward
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] acc;

  always_comb begin
    acc[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      acc[k] = !vld_q[k] || acc[k+1];
    end
  end

  assign s_axis_tready = acc[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  // Stage payload registers
  logic [PK_W-1:0]            px0_q, pz0_q;
  bhs_func_e                  func0_q, func1_q, func2_q;
  logic [IDX_W-1:0]           idx0_q, idx1_q;
  logic signed [SAMPLE_W-1:0] val0_q, val1_q, val2_q;

  logic [XW-1:0]     x0_q, x1_q;
  logic [ZW-1:0]     z0_q, z1_q;
  logic [FRAC_W-1:0] fx1_q, fz1_q, fx2_q, fz2_q, fx3_q, fz3_q, fz4_q;
  logic              zero1_q, zero2_q, zero3_q, zero4_q;

  logic [AW-1:0] a00_q, a10_q, a01_q, a11_q, wr_addr2_q;
  logic          wr_ok2_q;

  logic signed [APB_DATA_W-1:0] a0_q, a1_q;
  logic [HEIGHT_W-1:0]          height_q;

  // ---------------------------------------------------------------------------
  // Stage 0: coordinate times scale (grid units, 32 fraction bits)
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] px_d, pz_d;

  always_comb begin
    px_d = PROD_W'(s_axis_tdata[COORD_W-1:0]) * PROD_W'(scale_x_q);
    pz_d = PROD_W'(s_axis_tdata[2*COORD_W-1:COORD_W]) * PROD_W'(scale_z_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: cell index, clamped neighbour, fraction
  // ---------------------------------------------------------------------------
  logic [IP_W-1:0] ipx, ipz;
  logic [XW-1:0]   x0_d, x1_d;
  logic [ZW-1:0]   z0_d, z1_d;

  always_comb begin
    ipx  = px0_q[PK_W-1:FRAC_W];
    ipz  = pz0_q[PK_W-1:FRAC_W];
    x0_d = (ipx >= IP_W'(last_x)) ? last_x : XW'(ipx);
    z0_d = (ipz >= IP_W'(last_z)) ? last_z : ZW'(ipz);
    x1_d = (x0_d == last_x) ? x0_d : x0_d + XW'(1);
    z1_d = (z0_d == last_z) ? z0_d : z0_d + ZW'(1);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: linear store addresses (row * width + column)
  // ---------------------------------------------------------------------------
  logic [PW-1:0] row0, row1;
  logic [AW-1:0] a00_d, a10_d, a01_d, a11_d;

  always_comb begin
    row0  = PW'(z0_q) * PW'(w_eff);
    row1  = PW'(z1_q) * PW'(w_eff);
    a00_d = AW'(row0 + PW'(x0_q));
    a10_d = AW'(row0 + PW'(x1_q));
    a01_d = AW'(row1 + PW'(x0_q));
    a11_d = AW'(row1 + PW'(x1_q));
  end

  // ---------------------------------------------------------------------------
  // Stage 3: store access; writes land here too, keeping request order
  // ---------------------------------------------------------------------------
  bhs_store_ctl_t             store_ctl;
  logic signed [SAMPLE_W-1:0] h00, h10, h01, h11;

  always_comb begin
    store_ctl.wr_en = acc[3] && vld_q[2] && (func2_q == FUNC_WRITE) && wr_ok2_q;
    store_ctl.rd_en = acc[3] && vld_q[2] && (func2_q == FUNC_QUERY);
  end

  bhs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (store_ctl),
    .wr_addr_i (wr_addr2_q),
    .wr_data_i (val2_q),
    .rd_a00_i  (a00_q),
    .rd_a10_i  (a10_q),
    .rd_a01_i  (a01_q),
    .rd_a11_i  (a11_q),
    .h00_o     (h00),
    .h10_o     (h10),
    .h01_o     (h01),
    .h11_o     (h11)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: blend along x (16 fraction bits)
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W:0]            d10, d11;
  logic signed [FRAC_W:0]              fxs;
  logic signed [SAMPLE_W+FRAC_W+1:0]   m0, m1, s0, s1;

  always_comb begin
    d10 = (SAMPLE_W+1)'(h10) - (SAMPLE_W+1)'(h00);
    d11 = (SAMPLE_W+1)'(h11) - (SAMPLE_W+1)'(h01);
    fxs = $signed({1'b0, fx3_q});
    m0  = d10 * fxs;
    m1  = d11 * fxs;
    s0  = ((SAMPLE_W+FRAC_W+2)'(h00) <<< FRAC_W) + m0;
    s1  = ((SAMPLE_W+FRAC_W+2)'(h01) <<< FRAC_W) + m1;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: blend along z (32 fraction bits), floor to 8 fraction bits
  // ---------------------------------------------------------------------------
  logic signed [APB_DATA_W:0]          dz;
  logic signed [FRAC_W:0]              fzs;
  logic signed [APB_DATA_W+FRAC_W+1:0] mz, vz;

  always_comb begin
    dz  = (APB_DATA_W+1)'(a1_q) - (APB_DATA_W+1)'(a0_q);
    fzs = $signed({1'b0, fz4_q});
    mz  = dz * fzs;
    vz  = ((APB_DATA_W+FRAC_W+2)'(a0_q) <<< FRAC_W) + mz;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (acc[0]) vld_q[0] <= s_axis_tvalid;
      if (acc[1]) vld_q[1] <= vld_q[0];
      if (acc[2]) vld_q[2] <= vld_q[1];
      // writes retire at the store stage
      if (acc[3]) vld_q[3] <= vld_q[2] && (func2_q == FUNC_QUERY);
      if (acc[4]) vld_q[4] <= vld_q[3];
      if (acc[5]) vld_q[5] <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc[0]) begin
      px0_q   <= px_d[PROD_W-1:FRAC_W];
      pz0_q   <= pz_d[PROD_W-1:FRAC_W];
      func0_q <= bhs_func_e'(s_axis_tuser);
      idx0_q  <= s_axis_tdata[2*COORD_W+IDX_W-1:2*COORD_W];
      val0_q  <= $signed(s_axis_tdata[IN_TDATA_W-1:2*COORD_W+IDX_W]);
    end
    if (acc[1]) begin
      x0_q    <= x0_d;
      x1_q    <= x1_d;
      z0_q    <= z0_d;
      z1_q    <= z1_d;
      fx1_q   <= px0_q[FRAC_W-1:0];
      fz1_q   <= pz0_q[FRAC_W-1:0];
      zero1_q <= (w_eff == '0) || (h_eff == '0);
      func1_q <= func0_q;
      idx1_q  <= idx0_q;
      val1_q  <= val0_q;
    end
    if (acc[2]) begin
      a00_q      <= a00_d;
      a10_q      <= a10_d;
      a01_q      <= a01_d;
      a11_q      <= a11_d;
      wr_addr2_q <= AW'(idx1_q);
      wr_ok2_q   <= (32'(idx1_q) < 32'(DEPTH));
      val2_q     <= val1_q;
      fx2_q      <= fx1_q;
      fz2_q      <= fz1_q;
      zero2_q    <= zero1_q;
      func2_q    <= func1_q;
    end
    if (acc[3]) begin
      fx3_q   <= fx2_q;
      fz3_q   <= fz2_q;
      zero3_q <= zero2_q;
    end
    if (acc[4]) begin
      a0_q    <= APB_DATA_W'(s0);
      a1_q    <= APB_DATA_W'(s1);
      fz4_q   <= fz3_q;
      zero4_q <= zero3_q;
    end
    if (acc[5]) begin
      height_q <= zero4_q ? '0 : vz[HEIGHT_W+2*FRAC_W-9:2*FRAC_W-8];
    end
  end

  assign m_axis_tdata = height_q;

endmodule

// ===== rtl/bhs_store.sv =====
// Heightmap store: two identical copies, each with one write and two read ports.
module bhs_store import bhs_pkg::*; #(
  parameter int DEPTH = MAX_GRID_W_DEF * MAX_GRID_H_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  bhs_store_ctl_t             ctl_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic signed [SAMPLE_W-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_a00_i,
  input  logic [AW-1:0]              rd_a10_i,
  input  logic [AW-1:0]              rd_a01_i,
  input  logic [AW-1:0]              rd_a11_i,
  output logic signed [SAMPLE_W-1:0] h00_o,
  output logic signed [SAMPLE_W-1:0] h10_o,
  output logic signed [SAMPLE_W-1:0] h01_o,
  output logic signed [SAMPLE_W-1:0] h11_o
);

  // top copy serves the upper row, bottom copy the lower row
  logic signed [SAMPLE_W-1:0] mem_top [DEPTH];
  logic signed [SAMPLE_W-1:0] mem_bot [DEPTH];

  logic signed [SAMPLE_W-1:0] h00_q, h10_q, h01_q, h11_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_top[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      h00_q <= mem_top[rd_a00_i];
      h10_q <= mem_top[rd_a10_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_bot[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      h01_q <= mem_bot[rd_a01_i];
      h11_q <= mem_bot[rd_a11_i];
    end
  end

  assign h00_o = h00_q;
  assign h10_o = h10_q;
  assign h01_o = h01_q;
  assign h11_o = h11_q;

endmodule

// ===== tb/bhs_height_checker.sv =====
`timescale 1ns / 1ps
// Watches the sampler's request, result and APB channels, predicts each height and compares.
module bhs_height_checker import bhs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic                   s_ready_i,
  // [31:0] coord_x, [63:32] coord_z, [79:64] sample_index, [95:80] sample_value
  input  logic [IN_TDATA_W-1:0]  s_data_i,
  // [0] func
  input  logic                   s_user_i,
  input  logic                   m_valid_i,
  input  logic                   m_ready_i,
  // [23:0] height
  input  logic [OUT_TDATA_W-1:0] m_data_i,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic                   pready_i,
  input  logic [PADDR_W-1:0]     paddr_i,
  input  logic [APB_DATA_W-1:0]  pwdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int unsigned STORE_W = MAX_GRID_W_DEF;
  localparam int unsigned STORE_H = MAX_GRID_H_DEF;

  logic [DIM_W-1:0]   cfg_grid_w;
  logic [DIM_W-1:0]   cfg_grid_h;
  logic [SCALE_W-1:0] cfg_scale_x;
  logic [SCALE_W-1:0] cfg_scale_z;

  bit signed [SAMPLE_W-1:0] height_mem [STORE_W * STORE_H];
  logic [HEIGHT_W-1:0]      expected_heights [$];

  initial fail_count_o = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: height check: %s", $time, what);
    fail_count_o++;
  endtask

  // Cell index, right/lower neighbour (clamped) and 16-bit fraction along one axis
  function automatic void split_axis(input logic [COORD_W-1:0] coord,
                                     input logic [SCALE_W-1:0] scale,
                                     input int unsigned n,
                                     output int unsigned i0,
                                     output int unsigned i1,
                                     output logic [FRAC_W-1:0] frac);
    logic [63:0] p;
    logic [31:0] ip;
    p    = {32'd0, coord} * {40'd0, scale};
    ip   = p[63:32];
    i0   = (ip >= n - 1) ? n - 1 : ip;
    i1   = (i0 + 1 > n - 1) ? n - 1 : i0 + 1;
    frac = p[31:16];
  endfunction

  function automatic logic [HEIGHT_W-1:0] predict_height(input logic [COORD_W-1:0] cx,
                                                         input logic [COORD_W-1:0] cz);
    int unsigned w, h, x0, x1, z0, z1;
    logic [FRAC_W-1:0] fx, fz;
    longint h00, h10, h01, h11, a0, a1, v, r;
    w = (cfg_grid_w > STORE_W) ? STORE_W : cfg_grid_w;
    h = (cfg_grid_h > STORE_H) ? STORE_H : cfg_grid_h;
    if (w == 0 || h == 0) return '0;
    split_axis(cx, cfg_scale_x, w, x0, x1, fx);
    split_axis(cz, cfg_scale_z, h, z0, z1, fz);
    h00 = height_mem[z0 * w + x0];
    h10 = height_mem[z0 * w + x1];
    h01 = height_mem[z1 * w + x0];
    h11 = height_mem[z1 * w + x1];
    a0 = h00 * 65536 + (h10 - h00) * longint'(fx);
    a1 = h01 * 65536 + (h11 - h01) * longint'(fx);
    v  = a0 * 65536 + (a1 - a0) * longint'(fz);
    r  = v >>> 24;  // floor to 8 fraction bits
    return r[HEIGHT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [HEIGHT_W-1:0] want;
    if (!rst_ni) begin
      cfg_grid_w  = '0;
      cfg_grid_h  = '0;
      cfg_scale_x = '0;
      cfg_scale_z = '0;
      expected_heights.delete();
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (expected_heights.size() == 0) begin
          report_mismatch($sformatf("height %h with no query outstanding", m_data_i));
        end else begin
          want = expected_heights.pop_front();
          if (m_data_i !== want)
            report_mismatch($sformatf("height got %h want %h", m_data_i, want));
        end
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i === FUNC_QUERY)
          expected_heights.push_back(predict_height(s_data_i[31:0], s_data_i[63:32]));
        else
          height_mem[s_data_i[79:64]] = s_data_i[95:80];
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (bhs_reg_e'(paddr_i[3:2]))
          REG_GRID_W:  cfg_grid_w  = pwdata_i[DIM_W-1:0];
          REG_GRID_H:  cfg_grid_h  = pwdata_i[DIM_W-1:0];
          REG_SCALE_X: cfg_scale_x = pwdata_i[SCALE_W-1:0];
          REG_SCALE_Z: cfg_scale_z = pwdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_heights.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the bilinear heightmap sampler, checked by bhs_height_checker.
module tb;
  import bhs_pkg::*;

  localparam int unsigned STORE_W      = MAX_GRID_W_DEF;
  localparam int unsigned STORE_H      = MAX_GRID_H_DEF;
  localparam int          RANDOM_ITEMS = 850;
  localparam int          PHASE_ITEMS  = 110;
  // six register stages; idle margin before a register write and at the end
  localparam int          DRAIN_CYCLES = 16;
  localparam int          LONG_HOLD    = 300;
  localparam longint      TIMEOUT_NS   = 2_000_000;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  // [31:0] coord_x, [63:32] coord_z, [79:64] sample_index, [95:80] sample_value
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  // [0] func
  logic                   s_user  = 1'b0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  // [23:0] height
  logic [OUT_TDATA_W-1:0] m_data;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_W-1:0]     paddr   = '0;
  logic [APB_DATA_W-1:0]  pwdata  = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int fail_count;
  int pending;

  // Register values as last written, masked to their widths
  logic [DIM_W-1:0]   cur_w;
  logic [DIM_W-1:0]   cur_h;
  logic [SCALE_W-1:0] cur_sx;
  logic [SCALE_W-1:0] cur_sz;

  // Store entries written since reset; queries only ever touch these
  bit loaded_cells [STORE_W * STORE_H];

  bit calm      = 1'b0;  // no idling on either side
  bit long_hold = 1'b0;  // asks the receiver for one long hold-off

  // every request accepted so far, cell loads included
  int items_sent = 0;

  always #1 clk_i = ~clk_i;

  bilinear_heightmap_sampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bhs_height_checker height_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_user_i     (s_user),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Mostly short gaps, now and then a long one; none in a calm stretch
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] d, input int unsigned cap);
    return (d > cap) ? cap : d;
  endfunction

  // Truncated cell index along one axis, saturated at the last cell
  function automatic int unsigned base_cell(input logic [COORD_W-1:0] coord,
                                            input logic [SCALE_W-1:0] scale,
                                            input int unsigned n);
    logic [63:0] p;
    logic [31:0] ip;
    p  = {32'd0, coord} * {40'd0, scale};
    ip = p[63:32];
    return (ip >= n - 1) ? n - 1 : ip;
  endfunction

  // Coordinate that lands on a random cell (or one past the grid) with a random fraction
  function automatic logic [COORD_W-1:0] aim_coord(input logic [SCALE_W-1:0] scale,
                                                   input int unsigned n);
    logic [63:0] target;
    if (scale == 0) return $urandom;
    target = {32'($urandom_range(0, n)), 32'($urandom)};
    return 32'(target / scale);
  endfunction

  // Receiver: random tready, plus one long hold-off on request
  initial begin
    int busy;
    busy = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        busy = LONG_HOLD;
      end
      if (busy > 0) begin
        busy--;
        m_ready = 1'b0;
      end else begin
        m_ready = 1'b1;
        busy = idle_len();
      end
    end
  end

  // Offers one request after a random gap; returns at the edge that accepts it
  task automatic send_request(input bhs_func_e f, input logic [IN_TDATA_W-1:0] data);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = f;
    s_data  = data;
    do @(posedge clk_i); while (!s_ready);
    items_sent++;
  endtask

  // Sample write; coordinate fields carry noise
  task automatic write_sample(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    send_request(FUNC_WRITE, {val, idx, 32'($urandom), 32'($urandom)});
    loaded_cells[idx] = 1'b1;
  endtask

  task automatic fill_cell(input int unsigned addr);
    if (!loaded_cells[addr]) write_sample(IDX_W'(addr), SAMPLE_W'($urandom));
  endtask

  // Query; first loads any of the four neighbour cells that was never written
  task automatic query_at(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cz);
    int unsigned w, h, x0, x1, z0, z1;
    w = eff_dim(cur_w, STORE_W);
    h = eff_dim(cur_h, STORE_H);
    if (w != 0 && h != 0) begin
      x0 = base_cell(cx, cur_sx, w);
      z0 = base_cell(cz, cur_sz, h);
      x1 = (x0 + 1 < w) ? x0 + 1 : x0;
      z1 = (z0 + 1 < h) ? z0 + 1 : z0;
      fill_cell(z0 * w + x0);
      fill_cell(z0 * w + x1);
      fill_cell(z1 * w + x0);
      fill_cell(z1 * w + x1);
    end
    // index and sample fields are noise on a query
    send_request(FUNC_QUERY, {16'($urandom), 16'($urandom), cz, cx});
  endtask

  // Waits until every height has come back, plus the pipeline depth for trailing writes
  task automatic drain();
    @(negedge clk_i);
    s_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input bhs_reg_e r, input logic [APB_DATA_W-1:0] v);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Writes all four registers; bits above each register's width carry noise
  task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                          input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sz);
    apb_write(REG_GRID_W,  {23'($urandom), w});
    apb_write(REG_GRID_H,  {23'($urandom), h});
    apb_write(REG_SCALE_X, {8'($urandom), sx});
    apb_write(REG_SCALE_Z, {8'($urandom), sz});
    cur_w  = w;
    cur_h  = h;
    cur_sx = sx;
    cur_sz = sz;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 9'd0;
      1, 2:    return 9'd1;
      3, 4:    return 9'd2;
      5, 6:    return 9'd256;
      7:       return 9'd511;
      8:       return 9'($urandom_range(257, 510));
      default: return 9'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'h010000;
      2:       return 24'hFFFFFF;
      3:       return 24'($urandom);
      default: return 24'($urandom_range(24'h001000, 24'h080000));
    endcase
  endfunction

  task automatic random_query();
    int unsigned w, h;
    logic [COORD_W-1:0] cx, cz;
    w = eff_dim(cur_w, STORE_W);
    h = eff_dim(cur_h, STORE_H);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        cx = $urandom;
        cz = $urandom;
      end
      3, 4: begin
        cx = $urandom_range(0, 32'h3FFFF);
        cz = $urandom_range(0, 32'h3FFFF);
      end
      default: begin
        cx = aim_coord(cur_sx, w);
        cz = aim_coord(cur_sz, h);
      end
    endcase
    query_at(cx, cz);
  endtask

  // Noise write: inside the grid in use, or anywhere in the store
  task automatic random_write();
    int unsigned cells;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] val;
    cells = eff_dim(cur_w, STORE_W) * eff_dim(cur_h, STORE_H);
    if (cells != 0 && $urandom_range(0, 1) == 0)
      idx = IDX_W'($urandom_range(0, cells - 1));
    else
      idx = IDX_W'($urandom);
    case ($urandom_range(0, 9))
      0:       val = 16'h8000;
      1:       val = 16'h7FFF;
      default: val = 16'($urandom);
    endcase
    write_sample(idx, val);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int phase;
    int k;
    cur_w  = '0;
    cur_h  = '0;
    cur_sx = '0;
    cur_sz = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at reset: zero grid, every query gives 0
    query_at(32'h0, 32'h0);
    query_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // 2x2 grid at unit scale, samples at both extremes
    drain();
    set_grid(9'd2, 9'd2, 24'h010000, 24'h010000);
    write_sample(16'd0, 16'h7FFF);
    write_sample(16'd1, 16'h8000);
    write_sample(16'd2, 16'h8000);
    write_sample(16'd3, 16'h7FFF);
    query_at(32'h0, 32'h0);
    query_at(32'h8000, 32'h8000);
    query_at(32'hFFFF, 32'h0);
    query_at(32'hFFFF, 32'hFFFF);
    // far beyond the grid: both axes saturate on the last cell
    query_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Width and height above the store size fall back to the full store
    drain();
    set_grid(9'd511, 9'd511, 24'hFFFFFF, 24'hFFFFFF);
    query_at(32'h0, 32'h0);
    query_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // One dimension zero means no terrain
    drain();
    set_grid(9'd0, 9'd5, 24'h010000, 24'h010000);
    query_at(32'h0001_8000, 32'h0001_8000);
    drain();
    set_grid(9'd5, 9'd0, 24'h010000, 24'h010000);
    query_at(32'h0001_8000, 32'h0001_8000);

    // Single cell: every neighbour is the cell itself
    drain();
    set_grid(9'd1, 9'd1, 24'h010000, 24'hFFFFFF);
    query_at(32'h1234_5678, 32'hFFFF_FFFF);

    // Random phases: new registers each time, mostly queries with their cell loads
    for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      set_grid(pick_dim(), pick_dim(), pick_scale(), pick_scale());
      for (k = 0; k < PHASE_ITEMS && items_sent < RANDOM_ITEMS; k++) begin
        // once: receiver holds off while the sender streams back to back
        if (phase == 1 && k == 40) begin
          calm = 1'b1;
          long_hold = 1'b1;
        end
        if ($urandom_range(0, 9) < 7)
          random_query();
        else
          random_write();
      end
    end

    drain();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
